// ===== src/iff_pkg.sv =====
package iff_pkg;

   localparam int MaxWidthDefault = 48;

   // Conversion kinds
   localparam logic [2:0] FUNC_SDEC = 3'd0;
   localparam logic [2:0] FUNC_UDEC = 3'd1;
   localparam logic [2:0] FUNC_OCT  = 3'd2;
   localparam logic [2:0] FUNC_HEXL = 3'd3;
   localparam logic [2:0] FUNC_HEXU = 3'd4;
   localparam logic [2:0] FUNC_PTR  = 3'd5;
   localparam logic [2:0] FUNC_CHR  = 3'd6;
   localparam logic [2:0] FUNC_PCT  = 3'd7;

   // Flag bit positions
   localparam int FlagAlt   = 0;
   localparam int FlagZero  = 1;
   localparam int FlagLeft  = 2;
   localparam int FlagBlank = 3;
   localparam int FlagPlus  = 4;

   localparam logic [7:0] ChrZero  = 8'h30;
   localparam logic [7:0] ChrSpace = 8'h20;
   localparam logic [7:0] ChrMinus = 8'h2d;
   localparam logic [7:0] ChrPlus  = 8'h2b;
   localparam logic [7:0] ChrPct   = 8'h25;

   // Output sections, in emission order
   typedef enum logic [2:0] {
      SEC_PRE_A,
      SEC_LPAD,
      SEC_PRE_B,
      SEC_PREC,
      SEC_BODY,
      SEC_RPAD
   } sec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_PLAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;     // capture request, start setup
      logic conv;     // one extraction step: a digit, or one decimal limb
      logic plan;     // compute section lengths
      logic emit;     // advance to the next character
   } cmd_type;

   typedef struct packed {
      logic conv_done;
      logic emit_last;
   } sts_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) c = ChrZero + {4'd0, d};
      else if (upper) c = 8'h37 + {4'd0, d};
      else c = 8'h57 + {4'd0, d};
      return c;
   endfunction

endpackage

// ===== src/iff_ctrl.sv =====
module iff_ctrl
   import iff_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_CONV;
         ST_CONV: if (sts.conv_done) state_in = ST_PLAN;
         ST_PLAN: state_in = ST_EMIT;
         ST_EMIT: if (rsp_tready && sts.emit_last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            cmd.load   = req_tvalid && !reset;
         end
         ST_CONV: cmd.conv = 1'b1;
         ST_PLAN: cmd.plan = 1'b1;
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            cmd.emit   = rsp_tready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== src/iff_dp.sv =====
module iff_dp
   import iff_pkg::*;
#(
   parameter int MAX_WIDTH = MaxWidthDefault
) (
   input  logic        clock,
   input  logic [2:0]  func,
   input  logic [63:0] value,
   input  logic        wide,
   input  logic [4:0]  flag_bits,
   input  logic [5:0]  field_width,
   input  logic        has_precision,
   input  logic [5:0]  precision,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [7:0]  char_out,
   output logic        last
);

   localparam logic [6:0] MaxW = 7'(MAX_WIDTH);
   localparam logic [6:0] PtrW = (MAX_WIDTH > 16) ? 7'd16 : 7'(MAX_WIDTH);

   logic [2:0]  func_ff;
   logic [4:0]  flags_ff;
   logic [6:0]  width_ff;
   logic        hasp_ff;
   logic [6:0]  prec_ff;
   logic [63:0] mag_ff;
   logic        neg_ff, nz_ff;
   logic [7:0]  bodyc_ff;
   logic [3:0]  digs_ff [24];
   logic [4:0]  nd_ff;
   logic [1:0]  limb_ff;
   logic [3:0]  rem_ff;
   logic [1:0]  npre_ff;
   logic [7:0]  pre0_ff, pre1_ff;
   logic [6:0]  pad_ff, zer_ff;
   sec_type     sec_ff;
   logic [6:0]  cnt_ff;

   logic [6:0]  w_sat, p_sat;
   logic [63:0] mag_in;
   logic        neg_in;
   logic [3:0]  dig;
   logic [63:0] quo;
   logic        upper;
   logic        dec_mode, dig_ok;
   logic [19:0] dx, dq10;
   logic [39:0] dprod;
   logic [15:0] dq;

   assign w_sat = ({1'b0, field_width} > MaxW) ? MaxW : {1'b0, field_width};
   assign p_sat = ({1'b0, precision} > MaxW) ? MaxW : {1'b0, precision};
   assign upper = (func_ff == FUNC_HEXU);

   // Magnitude at capture
   always_comb begin
      neg_in = 1'b0;
      if (func == FUNC_PTR) mag_in = value;
      else if (func == FUNC_SDEC) begin
         if (wide) begin
            neg_in = value[63];
            mag_in = neg_in ? (64'd0 - value) : value;
         end else begin
            neg_in = value[31];
            mag_in = {32'd0, neg_in ? (32'd0 - value[31:0]) : value[31:0]};
         end
      end else mag_in = wide ? value : {32'd0, value[31:0]};
   end

   // Base 8 and 16: one digit per cycle by shift. Base 10: divide by ten one
   // 16-bit limb per cycle from the top, a digit after all four limbs, using a
   // reciprocal multiply on the 20-bit partial dividend
   always_comb begin
      dec_mode = (func_ff < FUNC_OCT) || (func_ff > FUNC_PTR);
      dx       = {rem_ff, mag_ff[{limb_ff, 4'd0} +: 16]};
      dprod    = {20'd0, dx} * 40'd838861;
      dq       = dprod[38:23];
      dq10     = {1'b0, dq, 3'd0} + {3'd0, dq, 1'b0};
      quo      = mag_ff;
      dig_ok   = 1'b1;
      if (func_ff == FUNC_OCT) begin
         dig = {1'b0, mag_ff[2:0]};
         quo = mag_ff >> 3;
      end else if (!dec_mode) begin
         dig = mag_ff[3:0];
         quo = mag_ff >> 4;
      end else begin
         dig = 4'(dx - dq10);
         quo[{limb_ff, 4'd0} +: 16] = dq;
         dig_ok = (limb_ff == 2'd0);
      end
   end

   logic        zp, lft;
   logic [6:0]  nb, mp;
   logic [6:0]  wid_eff;

   always_comb begin
      zp  = flags_ff[FlagZero] | (func_ff == FUNC_PTR);
      if (func_ff <= FUNC_PTR && hasp_ff) zp = 1'b0;
      lft = flags_ff[FlagLeft];
      nb  = (func_ff <= FUNC_PTR) ? {2'd0, nd_ff} : 7'd1;
      mp  = (func_ff <= FUNC_PTR && hasp_ff) ? prec_ff : 7'd0;
      wid_eff = (func_ff == FUNC_PTR && width_ff == 7'd0) ? PtrW : width_ff;
   end

   // Prefix and section lengths for the plan step
   logic [1:0] np;
   logic [7:0] pre0;
   logic [6:0] ln, pd, zr;

   always_comb begin
      np   = 2'd0;
      pre0 = ChrZero;
      if (func_ff == FUNC_SDEC) begin
         if (neg_ff) begin np = 2'd1; pre0 = ChrMinus; end
         else if (flags_ff[FlagPlus]) begin np = 2'd1; pre0 = ChrPlus; end
         else if (flags_ff[FlagBlank]) begin np = 2'd1; pre0 = ChrSpace; end
      end else if (func_ff >= FUNC_OCT && func_ff <= FUNC_PTR &&
                   flags_ff[FlagAlt] && nz_ff) begin
         if (func_ff == FUNC_OCT) np = (!hasp_ff || prec_ff != 7'd0) ? 2'd1 : 2'd0;
         else np = 2'd2;
      end
      ln = {5'd0, np} + ((nb >= mp) ? nb : mp);
      pd = (ln >= wid_eff) ? 7'd0 : wid_eff - ln;
      zr = (mp > nb) ? mp - nb : 7'd0;
   end

   logic [7:0] pad_chr;
   assign pad_chr = zp ? ChrZero : ChrSpace;

   // Next section after the current one runs out
   function automatic sec_type next_sec(input sec_type s, input logic [1:0] np,
                                        input logic [6:0] pd, input logic [6:0] zr,
                                        input logic z, input logic l);
      sec_type r;
      r = SEC_RPAD;
      case (s)
         SEC_PRE_A: r = (!l && pd != 0) ? SEC_LPAD :
                        (!z && np != 0) ? SEC_PRE_B : (zr != 0) ? SEC_PREC : SEC_BODY;
         SEC_LPAD:  r = (!z && np != 0) ? SEC_PRE_B : (zr != 0) ? SEC_PREC : SEC_BODY;
         SEC_PRE_B: r = (zr != 0) ? SEC_PREC : SEC_BODY;
         SEC_PREC:  r = SEC_BODY;
         default:   r = SEC_RPAD;
      endcase
      return r;
   endfunction

   logic [6:0] sec_len;
   always_comb begin
      case (sec_ff) inside
         SEC_PRE_A, SEC_PRE_B: sec_len = {5'd0, npre_ff};
         SEC_LPAD, SEC_RPAD:   sec_len = pad_ff;
         SEC_PREC:             sec_len = zer_ff;
         default:              sec_len = (func_ff <= FUNC_PTR) ? {2'd0, nd_ff} : 7'd1;
      endcase
   end

   logic sec_end;
   assign sec_end = (cnt_ff + 7'd1 == sec_len);

   // Current character
   always_comb begin
      case (sec_ff) inside
         SEC_PRE_A, SEC_PRE_B: char_out = (cnt_ff == 7'd0) ? pre0_ff : pre1_ff;
         SEC_LPAD:  char_out = pad_chr;
         SEC_PREC:  char_out = ChrZero;
         SEC_RPAD:  char_out = ChrSpace;
         default:   char_out = (func_ff <= FUNC_PTR) ?
                               digit_char(digs_ff[5'(nd_ff - 5'd1 - cnt_ff[4:0])], upper) :
                               bodyc_ff;
      endcase
      last = sec_end && ((sec_ff == SEC_RPAD) || (sec_ff == SEC_BODY && !(lft && pad_ff != 0)));
   end

   assign sts.conv_done = dig_ok && ((quo == 64'd0) || (nd_ff == 5'd23));
   assign sts.emit_last = last;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= func;
         flags_ff <= flag_bits;
         width_ff <= w_sat;
         hasp_ff  <= has_precision;
         prec_ff  <= p_sat;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         nz_ff    <= (mag_in != 64'd0);
         bodyc_ff <= (func == FUNC_CHR) ? value[7:0] : ChrPct;
         nd_ff    <= 5'd0;
         limb_ff  <= 2'd3;
         rem_ff   <= 4'd0;
      end
      if (cmd.conv) begin
         mag_ff <= quo;
         if (dig_ok) begin
            digs_ff[nd_ff] <= dig;
            nd_ff <= nd_ff + 5'd1;
         end
         rem_ff  <= dig_ok ? 4'd0 : dig;
         limb_ff <= limb_ff - 2'd1;
      end
      if (cmd.plan) begin
         npre_ff <= np;
         pre0_ff <= pre0;
         pre1_ff <= upper ? 8'h58 : 8'h78;
         pad_ff  <= pd;
         zer_ff  <= zr;
         cnt_ff  <= 7'd0;
         // first section: prefix before the left pad only with zero pad
         sec_ff  <= (zp && np != 2'd0) ? SEC_PRE_A : next_sec(SEC_PRE_A, np, pd, zr, zp, lft);
      end
      if (cmd.emit) begin
         if (sec_end) begin
            cnt_ff <= 7'd0;
            sec_ff <= next_sec(sec_ff, npre_ff, pad_ff, zer_ff, zp, lft);
         end else cnt_ff <= cnt_ff + 7'd1;
      end
   end

endmodule

// ===== src/integer_field_formatter.sv =====
// Integer field formatter: turns one parsed integer conversion into text.
// The req_ channel carries one conversion request (kind, value, flags,
// width, precision); the rsp_ channel returns its characters one per
// transfer, most significant first, with rsp_tlast on the final one.
// Each conversion yields between 1 and 50 characters.
// Timing: the request is captured at its accepting edge, then digits are
// extracted: by shift for octal (up to 22 digits) and hex (up to 16), and
// for decimal, character and percent by dividing the value by ten one 16-bit
// limb at a time from the top (up to 20 digits). A planning step follows,
// then one character per cycle while rsp_tready is high. The next request
// can be taken in the cycle after the last character is transferred.
// A stall on rsp_tready holds the current character and tlast unchanged.
// Reset (synchronous, active high) returns the controller to idle and
// drops any conversion in progress.
module integer_field_formatter
   import iff_pkg::*;
#(
   parameter int MAX_WIDTH = MaxWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] func, [66:3] value, [67] wide, [72:68] flag_bits,
   // [78:73] field_width, [79] has_precision, [85:80] precision
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] char_out
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   iff_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .sts(sts), .cmd(cmd)
   );

   iff_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock(clock),
      .func(req_tdata[2:0]),
      .value(req_tdata[66:3]),
      .wide(req_tdata[67]),
      .flag_bits(req_tdata[72:68]),
      .field_width(req_tdata[78:73]),
      .has_precision(req_tdata[79]),
      .precision(req_tdata[85:80]),
      .cmd(cmd), .sts(sts),
      .char_out(rsp_tdata),
      .last(rsp_tlast)
   );

endmodule
